>>> src/lz_token_stream_decoder_unit_assert.svh
// Assertion macros for the decoder RTL (used in lztsd_dpath).
// Expects clk and rst (synchronous, active high) in the including module.
`ifndef LZ_TOKEN_STREAM_DECODER_UNIT_ASSERT_SVH
`define LZ_TOKEN_STREAM_DECODER_UNIT_ASSERT_SVH

// same-cycle implication
`define LZTSD_CHK_NOW(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("lztsd check failed");

// next-cycle implication
`define LZTSD_CHK_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("lztsd check failed");

`endif

>>> src/lztsd_pkg.sv
// Package of the LZ token stream decoder: sizes, codes, enums and the
// command/status structs between controller and datapath. No dependencies.
package lztsd_pkg;

  localparam int WINDOW_DEPTH = 16384;
  localparam int HEADER_BYTES = 4;
  localparam int LANES        = 8;

  localparam int AW       = $clog2(WINDOW_DEPTH);
  localparam int HDR_W    = $clog2(HEADER_BYTES + 2);
  localparam int FILL_W   = $clog2(LANES + 1);
  localparam int LANE_IW  = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int COUNT_W  = 4;
  localparam int PC_W     = 25;
  localparam int RUN_W    = 9;
  localparam int DIST_W   = 14;
  localparam int LIT_W    = 6;
  localparam int OLEN_W   = 24;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic REG_OUT_LENGTH = 1'b0;

  // token class bounds
  localparam logic [7:0] TOK_LIT_MAX    = 8'h3F;
  localparam logic [7:0] TOK_RAMP8_MAX  = 8'h4F;
  localparam logic [7:0] TOK_RAMP16_MAX = 8'h5F;
  localparam logic [7:0] TOK_REP1_MAX   = 8'h6F;
  localparam logic [7:0] TOK_REP2_MAX   = 8'h7F;
  localparam logic [7:0] TOK_SREF_MAX   = 8'hBF;
  localparam logic [7:0] TOK_REF1_MAX   = 8'hDF;

  typedef enum logic [1:0] {
    ST_RUN = 2'd0,
    ST_OK  = 2'd1,
    ST_BAD = 2'd2,
    ST_LEN = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_TOKEN,
    PH_LITERAL,
    PH_NEED1,
    PH_NEED2
  } phase_t;

  typedef enum logic [2:0] {
    GEN_LIT,
    GEN_RAMP8,
    GEN_RAMP16,
    GEN_REP1,
    GEN_REP2,
    GEN_COPY
  } gen_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_PUT,
    S_FLUSH,
    S_EMPTY
  } state_t;

  typedef struct packed {
    logic capture;
    logic decode;
    logic read;
    logic put;
    logic flush;
    logic empty;
  } ctrl_cmd_t;

  typedef struct packed {
    logic ignore;
    logic no_bytes;
    logic final_nz;
    logic dec_copy;
    logic run_copy;
    logic ends_packet;
    logic remaining_zero;
    logic out_free;
  } dp_stat_t;

endpackage

>>> src/lztsd_ctrl.sv
// Sequencing controller of the LZ token stream decoder.
// Depends on lztsd_pkg; drives commands into lztsd_dpath.
module lztsd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  lztsd_pkg::dp_stat_t   stat,
  output lztsd_pkg::ctrl_cmd_t  cmd
);
  import lztsd_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (stat.ignore) state_next = S_IDLE;
        else if (stat.no_bytes) state_next = stat.final_nz ? S_EMPTY : S_IDLE;
        else state_next = stat.dec_copy ? S_READ : S_PUT;
      end
      S_READ: state_next = S_PUT;
      S_PUT: begin
        if (stat.ends_packet) state_next = S_FLUSH;
        else state_next = stat.run_copy ? S_READ : S_PUT;
      end
      S_FLUSH: begin
        if (stat.out_free) begin
          if (stat.remaining_zero) state_next = S_IDLE;
          else state_next = stat.run_copy ? S_READ : S_PUT;
        end
      end
      S_EMPTY: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      S_DECODE: cmd.decode = 1'b1;
      S_READ:   cmd.read   = 1'b1;
      S_PUT:    cmd.put    = 1'b1;
      S_FLUSH:  cmd.flush  = stat.out_free;
      S_EMPTY:  cmd.empty  = stat.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> src/lztsd_dpath.sv
// Datapath of the LZ token stream decoder: token decode, history window RAM,
// byte generators, lane packer and output register. Depends on lztsd_pkg.
`include "lz_token_stream_decoder_unit_assert.svh"
module lztsd_dpath (
  input  logic                           clk,
  input  logic                           rst,
  input  lztsd_pkg::ctrl_cmd_t           cmd,
  output lztsd_pkg::dp_stat_t            stat,
  input  logic [7:0]                     in_byte,
  input  logic                           in_last,
  input  logic [lztsd_pkg::OLEN_W-1:0]   out_length,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_lane [lztsd_pkg::LANES],
  output logic [lztsd_pkg::COUNT_W-1:0]  out_count,
  output logic                           out_end,
  output lztsd_pkg::status_t             out_status
);
  import lztsd_pkg::*;

  // step state
  phase_t             phase;
  logic [HDR_W-1:0]   header_left;
  logic [7:0]         held_token;
  logic [7:0]         held_offset_low;
  logic [LIT_W-1:0]   literals_left;
  status_t            final_state;
  logic [PC_W-1:0]    produced_count;
  logic [AW-1:0]      wptr;
  logic [7:0]         last1, last2, last3, last4;
  logic [7:0]         cap_byte;
  logic               cap_last;

  // run state
  gen_t               kind;
  logic [RUN_W-1:0]   remaining;
  logic [AW-1:0]      src;
  status_t            run_status;
  logic [7:0]         d8;
  logic [15:0]        d16;
  logic [7:0]         whi;
  logic               odd;
  logic [7:0]         ram_q;

  logic [7:0]         lanes [LANES];
  logic [FILL_W-1:0]  fill;

  logic [7:0]         hist_mem [WINDOW_DEPTH];

  // decode results
  phase_t             ph_n;
  logic [HDR_W-1:0]   hl_n;
  logic [7:0]         ht_n, hol_n;
  logic [LIT_W-1:0]   ll_n;
  logic [RUN_W-1:0]   n;
  gen_t               kind_n;
  logic [DIST_W-1:0]  ref_dist;
  logic               chk_dist, ok, surplus;
  logic [PC_W-1:0]    pc_after;
  status_t            fs_n;
  logic [AW:0]        wext, dext, src_calc;

  logic               out_free;
  logic [7:0]         pbyte;
  logic [15:0]        wsum;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    ph_n     = phase;
    hl_n     = header_left;
    ht_n     = held_token;
    hol_n    = held_offset_low;
    ll_n     = literals_left;
    n        = '0;
    kind_n   = GEN_LIT;
    ref_dist = '0;
    chk_dist = 1'b0;
    ok       = 1'b1;
    surplus  = 1'b0;
    case (phase)
      PH_HEADER: begin
        if (header_left != '0) hl_n = header_left - 1'b1;
        if (hl_n == '0) ph_n = PH_TOKEN;
      end
      PH_LITERAL: begin
        n = RUN_W'(1);
        if (literals_left != '0) ll_n = literals_left - 1'b1;
        if (ll_n == '0) ph_n = PH_TOKEN;
      end
      PH_NEED1: begin
        if (held_token <= TOK_REF1_MAX) begin
          ph_n     = PH_TOKEN;
          ref_dist = DIST_W'({held_token[1:0], cap_byte}) + DIST_W'(3);
          n        = RUN_W'(held_token[4:2]) + RUN_W'(4);
          kind_n   = GEN_COPY;
          chk_dist = 1'b1;
        end else begin
          hol_n = cap_byte;
          ph_n  = PH_NEED2;
        end
      end
      PH_NEED2: begin
        ph_n     = PH_TOKEN;
        ref_dist = DIST_W'({held_token[4:0], held_offset_low}) + DIST_W'(3);
        n        = RUN_W'(cap_byte) + RUN_W'(5);
        kind_n   = GEN_COPY;
        chk_dist = 1'b1;
      end
      default: begin
        ph_n = PH_TOKEN;
        if (produced_count == PC_W'(out_length)) begin
          surplus = 1'b1;
        end else begin
          case (cap_byte) inside
            [8'h00:TOK_LIT_MAX]: begin
              if (cap_byte != 8'h00) begin
                ll_n = cap_byte[LIT_W-1:0];
                ph_n = PH_LITERAL;
              end
            end
            [8'h40:TOK_RAMP8_MAX]: begin
              ok     = produced_count >= PC_W'(2);
              n      = RUN_W'(cap_byte[3:0]) + RUN_W'(3);
              kind_n = GEN_RAMP8;
            end
            [8'h50:TOK_RAMP16_MAX]: begin
              ok     = produced_count >= PC_W'(4);
              n      = (RUN_W'(cap_byte[3:0]) + RUN_W'(2)) << 1;
              kind_n = GEN_RAMP16;
            end
            [8'h60:TOK_REP1_MAX]: begin
              ok     = produced_count >= PC_W'(1);
              n      = RUN_W'(cap_byte[3:0]) + RUN_W'(3);
              kind_n = GEN_REP1;
            end
            [8'h70:TOK_REP2_MAX]: begin
              ok     = produced_count >= PC_W'(2);
              n      = (RUN_W'(cap_byte[3:0]) + RUN_W'(2)) << 1;
              kind_n = GEN_REP2;
            end
            [8'h80:TOK_SREF_MAX]: begin
              ref_dist = DIST_W'(cap_byte[5:0]) + DIST_W'(3);
              n        = RUN_W'(3);
              kind_n   = GEN_COPY;
              chk_dist = 1'b1;
            end
            default: begin
              ht_n = cap_byte;
              ph_n = PH_NEED1;
            end
          endcase
        end
      end
    endcase
    if (chk_dist) ok = produced_count >= PC_W'(ref_dist);
    if (!ok) n = '0;
    pc_after = produced_count + PC_W'(n);

    if (surplus) fs_n = ST_OK;
    else if (!ok) fs_n = ST_BAD;
    else if (pc_after > PC_W'(out_length)) fs_n = ST_LEN;
    else if (ph_n == PH_TOKEN && pc_after == PC_W'(out_length)) fs_n = ST_OK;
    else if (cap_last)
      fs_n = (ph_n == PH_HEADER && pc_after == PC_W'(out_length)) ? ST_OK : ST_LEN;
    else fs_n = ST_RUN;
  end

  // copy source, wrapped into the window
  always_comb begin
    wext     = {1'b0, wptr};
    dext     = (AW+1)'(ref_dist);
    src_calc = (wext >= dext) ? (wext - dext) : (wext + (AW+1)'(WINDOW_DEPTH) - dext);
  end

  always_comb begin
    wsum = {last1, last2} + d16;
    case (kind)
      GEN_LIT:    pbyte = cap_byte;
      GEN_RAMP8:  pbyte = last1 + d8;
      GEN_RAMP16: pbyte = odd ? whi : wsum[7:0];
      GEN_REP1:   pbyte = last1;
      GEN_REP2:   pbyte = last2;
      default:    pbyte = ram_q;
    endcase
  end

  always_comb begin
    stat.ignore         = final_state != ST_RUN;
    stat.no_bytes       = n == '0;
    stat.final_nz       = fs_n != ST_RUN;
    stat.dec_copy       = kind_n == GEN_COPY;
    stat.run_copy       = kind == GEN_COPY;
    stat.ends_packet    = (fill == FILL_W'(LANES - 1)) || (remaining == RUN_W'(1));
    stat.remaining_zero = remaining == '0;
    stat.out_free       = out_free;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= (HEADER_BYTES == 0) ? PH_TOKEN : PH_HEADER;
      header_left     <= HDR_W'(HEADER_BYTES);
      held_token      <= '0;
      held_offset_low <= '0;
      literals_left   <= '0;
      final_state     <= ST_RUN;
      produced_count  <= '0;
      wptr            <= '0;
      remaining       <= '0;
      fill            <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cmd.decode && final_state == ST_RUN) begin
        phase           <= ph_n;
        header_left     <= hl_n;
        held_token      <= ht_n;
        held_offset_low <= hol_n;
        literals_left   <= ll_n;
        final_state     <= fs_n;
        produced_count  <= pc_after;
        remaining       <= n;
      end
      if (cmd.put) begin
        wptr      <= (wptr == AW'(WINDOW_DEPTH - 1)) ? '0 : wptr + 1'b1;
        remaining <= remaining - 1'b1;
        fill      <= fill + 1'b1;
      end
      if (cmd.flush) fill <= '0;
      if (cmd.flush || cmd.empty) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_byte <= in_byte;
      cap_last <= in_last;
    end
    if (cmd.decode) begin
      kind       <= kind_n;
      run_status <= fs_n;
      src        <= src_calc[AW-1:0];
      d8         <= last1 - last2;
      d16        <= {last1, last2} - {last3, last4};
      odd        <= 1'b0;
    end
    if (cmd.read) begin
      src <= (src == AW'(WINDOW_DEPTH - 1)) ? '0 : src + 1'b1;
    end
    if (cmd.put) begin
      last1 <= pbyte;
      last2 <= last1;
      last3 <= last2;
      last4 <= last3;
      odd   <= !odd;
      if (!odd) whi <= wsum[15:8];
      lanes[fill[LANE_IW-1:0]] <= pbyte;
    end
    if (cmd.flush) begin
      for (int j = 0; j < LANES; j++) begin
        out_lane[j] <= (FILL_W'(j) < fill) ? lanes[j] : 8'h00;
      end
      out_count  <= COUNT_W'(fill);
      out_end    <= remaining == '0;
      out_status <= run_status;
    end
    if (cmd.empty) begin
      for (int j = 0; j < LANES; j++) begin
        out_lane[j] <= 8'h00;
      end
      out_count  <= '0;
      out_end    <= 1'b1;
      out_status <= run_status;
    end
  end

  // history window
  always_ff @(posedge clk) begin
    if (cmd.put) hist_mem[wptr] <= pbyte;
  end

  always_ff @(posedge clk) begin
    if (cmd.read) ram_q <= hist_mem[src];
  end

  `LZTSD_CHK_NOW(a_flush_free, cmd.flush || cmd.empty, !out_valid || !out_stall)
  `LZTSD_CHK_NOW(a_put_has_work, cmd.put, remaining != '0)
  `LZTSD_CHK_NOW(a_empty_final, out_valid && out_count == '0, out_end && out_status != ST_RUN)
  `LZTSD_CHK_NEXT(a_fill_cleared, cmd.flush, fill == '0)

endmodule

>>> src/lz_token_stream_decoder_unit.sv
// Steps: accept, decode, then a put per literal/ramp/repeat byte and, for each
// back-reference byte, a window RAM read and then the write (put), plus a flush per result.
// One input byte in flight; in_stall holds the next until the block is back in idle.
// Reset (rst, synchronous): header skip, counts zero, status running, out_length 0.
// The window RAM is not cleared; unread history is never referenced within bounds.
// Holds the APB register and ties lztsd_ctrl and lztsd_dpath; depends on lztsd_pkg.
module lz_token_stream_decoder_unit (
  input  logic                             clk,
  input  logic                             rst,
  // APB configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lztsd_pkg::APB_AW-1:0]     paddr,
  input  logic [lztsd_pkg::APB_DW-1:0]     pwdata,
  output logic [lztsd_pkg::APB_DW-1:0]     prdata,
  output logic                             pready,
  // compressed byte stream
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_byte,
  input  logic                             in_last,
  // decoded results
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_byte_0,
  output logic [7:0]                       out_byte_1,
  output logic [7:0]                       out_byte_2,
  output logic [7:0]                       out_byte_3,
  output logic [7:0]                       out_byte_4,
  output logic [7:0]                       out_byte_5,
  output logic [7:0]                       out_byte_6,
  output logic [7:0]                       out_byte_7,
  output logic [lztsd_pkg::COUNT_W-1:0]    byte_count,
  output logic                             run_end,
  output logic [1:0]                       status
);
  import lztsd_pkg::*;

  logic [OLEN_W-1:0] out_length;
  logic              reg_hit;
  ctrl_cmd_t         cmd;
  dp_stat_t          stat;
  logic [7:0]        lane [LANES];
  status_t           st;

  // register index sits above the word offset
  assign reg_hit = paddr[APB_AW-1:2] == REG_OUT_LENGTH;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? APB_DW'(out_length) : '0;

  // write transfer completes in the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      out_length <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      out_length <= pwdata[OLEN_W-1:0];
    end
  end

  lztsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  lztsd_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .out_length (out_length),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_lane   (lane),
    .out_count  (byte_count),
    .out_end    (run_end),
    .out_status (st)
  );

  // lanes out in stream order, unused lanes already zeroed
  assign out_byte_0 = lane[0];
  assign out_byte_1 = lane[1];
  assign out_byte_2 = lane[2];
  assign out_byte_3 = lane[3];
  assign out_byte_4 = lane[4];
  assign out_byte_5 = lane[5];
  assign out_byte_6 = lane[6];
  assign out_byte_7 = lane[7];
  assign status     = st;

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for lz_token_stream_decoder_unit: a random token stream
// with an in-bench decode model. Depends on lztsd_pkg and the decoder RTL.
module tb;
  import lztsd_pkg::*;

  // token classes the stream builder picks from
  typedef enum int {K_LIT, K_RAMP8, K_RAMP16, K_REP1, K_REP2, K_SREF, K_REF1, K_REF2} tok_kind_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } in_item_t;

  typedef struct {
    logic [7:0] lane [LANES];
    logic [3:0] cnt;
    logic       run_end;
    logic [1:0] st;
  } out_word_t;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0, in_last = 1'b0;
  logic [7:0] in_byte = '0;
  logic in_stall;
  logic out_valid, out_stall = 1'b0;
  logic [7:0] ob [LANES];
  logic [COUNT_W-1:0] byte_count;
  logic run_end;
  logic [1:0] status;

  lz_token_stream_decoder_unit u_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .in_byte, .in_last,
    .out_valid, .out_stall,
    .out_byte_0(ob[0]), .out_byte_1(ob[1]), .out_byte_2(ob[2]), .out_byte_3(ob[3]),
    .out_byte_4(ob[4]), .out_byte_5(ob[5]), .out_byte_6(ob[6]), .out_byte_7(ob[7]),
    .byte_count, .run_end, .status
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // bookkeeping
  in_item_t  stream_q [$];      // bytes waiting for the driver
  out_word_t decoded_q [$];     // decoded words still owed by the DUT
  int pushed = 0;
  int accepted = 0;
  int errors = 0;
  int cyc = 0;
  logic calm;                   // stretches with no idling on either side

  always @(posedge clk) cyc <= cyc + 1;
  assign calm = ((cyc / 1500) % 3) == 1;

  // ---------------------------------------------------------------------------
  // Decode model: window, produced count, phase and status kept at block widths.
  // ---------------------------------------------------------------------------
  logic [7:0]        win [WINDOW_DEPTH];
  logic [PC_W-1:0]   m_count = '0;
  phase_t            m_phase = (HEADER_BYTES == 0) ? PH_TOKEN : PH_HEADER;
  int                m_hdr_left = HEADER_BYTES;
  logic [7:0]        m_tok = '0;
  logic [7:0]        m_off_lo = '0;
  int                m_lit_left = 0;
  status_t           m_final = ST_RUN;
  logic [OLEN_W-1:0] m_olen = '0;
  logic [7:0]        run_bytes [$];

  function automatic logic [7:0] win_back(int span);
    logic [PC_W-1:0] idx;
    idx = m_count - PC_W'(span);
    return win[idx[AW-1:0]];
  endfunction

  function automatic void win_put(logic [7:0] b);
    win[m_count[AW-1:0]] = b;
    m_count = m_count + 1'b1;
    run_bytes = {run_bytes, b};
  endfunction

  // overlapping back-copy; a distance past the produced count is a bad reference
  function automatic bit win_copy(int span, int len);
    if (m_count < span) return 1'b0;
    for (int i = 0; i < len; i++) win_put(win_back(span));
    return 1'b1;
  endfunction

  function automatic bit decode_token(logic [7:0] t);
    int n;
    logic [7:0] d8;
    logic [15:0] d16, w;
    n = int'(t[3:0]);
    if (t <= TOK_LIT_MAX) begin
      if (t != 0) begin
        m_lit_left = int'(t);
        m_phase = PH_LITERAL;
      end
    end else if (t <= TOK_RAMP8_MAX) begin
      if (m_count < 2) return 1'b0;
      d8 = win_back(1) - win_back(2);
      for (int i = 0; i < n + 3; i++) win_put(win_back(1) + d8);
    end else if (t <= TOK_RAMP16_MAX) begin
      if (m_count < 4) return 1'b0;
      d16 = {win_back(1), win_back(2)} - {win_back(3), win_back(4)};
      for (int i = 0; i < n + 2; i++) begin
        w = {win_back(1), win_back(2)} + d16;
        win_put(w[7:0]);
        win_put(w[15:8]);
      end
    end else if (t <= TOK_REP1_MAX) begin
      return win_copy(1, n + 3);
    end else if (t <= TOK_REP2_MAX) begin
      return win_copy(2, 2 * (n + 2));
    end else if (t <= TOK_SREF_MAX) begin
      return win_copy(int'(t[5:0]) + 3, 3);
    end else begin
      m_tok = t;
      m_phase = PH_NEED1;
    end
    return 1'b1;
  endfunction

  // one accepted stream byte -> expected output words
  task automatic predict_transfer(logic [7:0] b, logic last);
    bit ok;
    int nwords, cnt;
    out_word_t w;
    ok = 1'b1;
    if (m_final != ST_RUN) return;   // stream closed, byte dropped silently
    run_bytes.delete();
    case (m_phase)
      PH_HEADER: begin
        if (m_hdr_left > 0) m_hdr_left--;
        if (m_hdr_left == 0) m_phase = PH_TOKEN;
      end
      PH_LITERAL: begin
        win_put(b);
        if (m_lit_left > 0) m_lit_left--;
        if (m_lit_left == 0) m_phase = PH_TOKEN;
      end
      PH_NEED1: begin
        if (m_tok <= TOK_REF1_MAX) begin
          m_phase = PH_TOKEN;
          ok = win_copy(int'(m_tok[1:0]) * 256 + int'(b) + 3, int'(m_tok[4:2]) + 4);
        end else begin
          m_off_lo = b;
          m_phase = PH_NEED2;
        end
      end
      PH_NEED2: begin
        m_phase = PH_TOKEN;
        ok = win_copy(int'(m_tok[4:0]) * 256 + int'(m_off_lo) + 3, int'(b) + 5);
      end
      default: begin
        m_phase = PH_TOKEN;
        if (m_count == m_olen) m_final = ST_OK;   // surplus token byte
        else ok = decode_token(b);
      end
    endcase

    if (m_final == ST_RUN) begin
      if (!ok) m_final = ST_BAD;
      else if (m_count > m_olen) m_final = ST_LEN;
      else if (m_phase == PH_TOKEN && m_count == m_olen) m_final = ST_OK;
      else if (last)
        m_final = (m_phase == PH_HEADER && m_count == m_olen) ? ST_OK : ST_LEN;
    end

    if (run_bytes.size() == 0) begin
      if (m_final == ST_RUN) return;
      foreach (w.lane[j]) w.lane[j] = '0;
      w.cnt = '0;
      w.run_end = 1'b1;
      w.st = m_final;
      decoded_q = {decoded_q, w};
      return;
    end
    nwords = (run_bytes.size() + LANES - 1) / LANES;
    for (int k = 0; k < nwords; k++) begin
      cnt = run_bytes.size() - k * LANES;
      if (cnt > LANES) cnt = LANES;
      foreach (w.lane[j]) w.lane[j] = (j < cnt) ? run_bytes[k * LANES + j] : 8'h00;
      w.cnt = 4'(cnt);
      w.run_end = (k == nwords - 1);
      w.st = m_final;
      decoded_q = {decoded_q, w};
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: holds a byte until its transfer, then a random gap.
  // ---------------------------------------------------------------------------
  int gap = 0;
  in_item_t nxt;

  always @(posedge clk) begin
    if (!rst && (!in_valid || !in_stall)) begin
      if (gap > 0) begin
        gap <= gap - 1;
        in_valid <= 1'b0;
      end else if (stream_q.size() != 0) begin
        nxt = stream_q.pop_front();
        in_byte <= nxt.data;
        in_last <= nxt.last;
        in_valid <= 1'b1;
        if (calm) gap <= 0;
        else begin
          case ($urandom_range(0, 15))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9: gap <= 0;
            10, 11, 12, 13:               gap <= $urandom_range(1, 3);
            default:                      gap <= $urandom_range(10, 40);
          endcase
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // input transfer monitor feeds the model
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      predict_transfer(in_byte, in_last);
      accepted++;
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: random stalls, one long hold-off, field-by-field compare.
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  int words_seen = 0;
  bit held_long = 1'b0;
  out_word_t exp_w;

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        words_seen++;
        if (decoded_q.size() == 0) begin
          $error("unexpected output word: out_byte_0=%0h byte_count=%0d status=%0d",
                 ob[0], byte_count, status);
          errors++;
        end else begin
          exp_w = decoded_q.pop_front();
          for (int j = 0; j < LANES; j++)
            if (ob[j] !== exp_w.lane[j]) begin
              $error("out_byte_%0d: expected %0h, got %0h", j, exp_w.lane[j], ob[j]);
              errors++;
            end
          if (byte_count !== exp_w.cnt) begin
            $error("byte_count: expected %0d, got %0d", exp_w.cnt, byte_count);
            errors++;
          end
          if (run_end !== exp_w.run_end) begin
            $error("run_end: expected %0b, got %0b", exp_w.run_end, run_end);
            errors++;
          end
          if (status !== exp_w.st) begin
            $error("status: expected %0d, got %0d", exp_w.st, status);
            errors++;
          end
        end
      end
      // stall pattern; the long hold lets the block back up into its input
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (!held_long && words_seen >= 60) begin
        held_long <= 1'b1;
        stall_left <= 600;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(15, 50)
                                                   : $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: cycles without any transfer on either stream
  int quiet = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Register access
  // ---------------------------------------------------------------------------
  task automatic reg_write(logic [OLEN_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_AW'(REG_OUT_LENGTH) << 2;
    pwdata <= APB_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    m_olen = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    // read back
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[OLEN_W-1:0] !== value) begin
      $error("out_length readback: expected %0h, got %0h", value, prdata[OLEN_W-1:0]);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Stream builder: tracks the produced count so no reference reaches past it.
  // ---------------------------------------------------------------------------
  int gen_count = 0;

  task automatic add(logic [7:0] b, logic last = 1'b0);
    in_item_t it;
    it.data = b;
    it.last = last;
    stream_q = {stream_q, it};
    pushed++;
  endtask

  // token plus its extra bytes; literal content is random
  task automatic emit_tok(logic [7:0] t, logic [7:0] x = 8'h00, logic [7:0] y = 8'h00);
    int n;
    n = int'(t[3:0]);
    add(t);
    if (t <= TOK_LIT_MAX) begin
      for (int i = 0; i < int'(t); i++) add(8'($urandom));
      gen_count += int'(t);
    end else if (t <= TOK_RAMP8_MAX) gen_count += n + 3;
    else if (t <= TOK_RAMP16_MAX) gen_count += 2 * (n + 2);
    else if (t <= TOK_REP1_MAX) gen_count += n + 3;
    else if (t <= TOK_REP2_MAX) gen_count += 2 * (n + 2);
    else if (t <= TOK_SREF_MAX) gen_count += 3;
    else if (t <= TOK_REF1_MAX) begin
      add(x);
      gen_count += int'(t[4:2]) + 4;
    end else begin
      add(x);
      add(y);
      gen_count += int'(y) + 5;
    end
  endtask

  task automatic emit_random();
    tok_kind_t k;
    int d, dmax;
    logic [7:0] t;
    k = tok_kind_t'($urandom_range(0, 7));
    // fall back to a literal when history is too short for the pick
    if ((k == K_RAMP8 && gen_count < 2) || (k == K_RAMP16 && gen_count < 4) ||
        (k == K_REP1 && gen_count < 1) || (k == K_REP2 && gen_count < 2) ||
        (k >= K_SREF && gen_count < 3))
      k = K_LIT;
    case (k)
      K_LIT:
        emit_tok(8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 6)));
      K_RAMP8:  emit_tok(8'h40 | 8'($urandom_range(0, 15)));
      K_RAMP16: emit_tok(8'h50 | 8'($urandom_range(0, 15)));
      K_REP1:   emit_tok(8'h60 | 8'($urandom_range(0, 15)));
      K_REP2:   emit_tok(8'h70 | 8'($urandom_range(0, 15)));
      K_SREF: begin
        dmax = (gen_count < 66) ? gen_count : 66;
        d = $urandom_range(3, dmax);
        emit_tok(8'h80 | 8'(d - 3));
      end
      K_REF1: begin
        dmax = (gen_count < 1026) ? gen_count : 1026;
        d = $urandom_range(3, dmax);
        t = 8'hC0 | 8'($urandom_range(0, 7) << 2) | 8'((d - 3) >> 8);
        emit_tok(t, 8'(d - 3));
      end
      default: begin
        dmax = (gen_count < 8194) ? gen_count : 8194;
        d = $urandom_range(3, dmax);
        emit_tok(8'hE0 | 8'((d - 3) >> 8), 8'(d - 3),
                 8'(($urandom_range(0, 7) == 0) ? $urandom_range(100, 255)
                                                 : $urandom_range(0, 20)));
      end
    endcase
  endtask

  // sender pause: wait for every transfer and word, then the block's tail latency
  task automatic wait_drained();
    do @(negedge clk);
    while (stream_q.size() != 0 || accepted != pushed || decoded_q.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    reg_write('0);
    reg_write({OLEN_W{1'b1}});

    // header, then each token class at its low code, the classes up to 0xBF also at their high code
    add(8'h00); add(8'hFF); add(8'h5A); add(8'hA5);
    emit_tok(8'h00);
    add(8'h02); add(8'h00); add(8'hFF); gen_count += 2;
    emit_tok(8'h3F);
    emit_tok(8'h40); emit_tok(8'h4F);
    emit_tok(8'h50); emit_tok(8'h5F);
    emit_tok(8'h60); emit_tok(8'h6F);
    emit_tok(8'h70); emit_tok(8'h7F);
    emit_tok(8'h80); emit_tok(8'hBF);
    emit_tok(8'hC0, 8'h00);
    emit_tok(8'hE0, 8'h00, 8'h00);

    // grow history with longest overlapping copies, then the farthest references
    while (gen_count <= 8194) emit_tok(8'hE0, 8'h00, 8'hFF);
    emit_tok(8'hDF, 8'hFF);
    emit_tok(8'hFF, 8'hFF, 8'hFF);

    while (pushed < 220) emit_random();
    wait_drained();
    // different length limit mid-stream, still far above what gets produced
    reg_write(OLEN_W'(gen_count + (1 << 20)));
    while (pushed < 268) emit_random();
    wait_drained();

    // limit equal to the count: the next token byte closes the stream as complete
    reg_write(OLEN_W'(gen_count));
    add(8'($urandom), 1'b1);
    add(8'($urandom));          // dropped after the final status
    wait_drained();
    repeat (50) @(posedge clk);

    if (errors == 0 && decoded_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
